### src/kdmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the key debounce make/break block: widths, lane layout and shared types.
// No dependencies.
package kdmb_pkg;

   localparam int CodeWidth   = 16;
   localparam int CountWidth  = 2;
   localparam int TickWidth   = 32;
   localparam int ScansWidth  = 4;
   localparam int HoldWidth   = 4;
   localparam int SlotCount   = 2;
   localparam int LaneCount   = 2 * SlotCount;
   localparam int LaneIdxWidth = $clog2(LaneCount);

   localparam logic [ScansWidth-1:0] StableReset = ScansWidth'(7);
   localparam logic [HoldWidth-1:0]  HoldReset   = HoldWidth'(5);
   localparam logic [CountWidth-1:0] CountMax    = CountWidth'(2);

   // lanes 0..1 check old slots (break), lanes 2..3 check new slots (make)
   localparam logic [LaneIdxWidth-1:0] FirstMakeLane = LaneIdxWidth'(SlotCount);

   typedef struct packed {
      logic [LaneCount-1:0]                hit;
      logic [LaneCount-1:0][CodeWidth-1:0] code;
      logic [TickWidth-1:0]                tick;
   } event_batch_type;

   typedef struct packed {
      logic busy;
      logic last;
   } drain_status_type;

endpackage
`default_nettype wire

### src/kdmb_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel interfaces: scan request, event response and configuration write.
// Depends on kdmb_pkg.
interface kdmb_req_if;
   import kdmb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CountWidth-1:0] key_count;
   logic [CodeWidth-1:0]  first_code;
   logic [CodeWidth-1:0]  second_code;
   logic [TickWidth-1:0]  tick_stamp;
   modport source (output valid, key_count, first_code, second_code, tick_stamp,
                   input ready);
   modport sink   (input valid, key_count, first_code, second_code, tick_stamp,
                   output ready);
endinterface

interface kdmb_rsp_if;
   import kdmb_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 is_release;
   logic [CodeWidth-1:0] event_code;
   logic [TickWidth-1:0] event_tick;
   logic                 final_event;
   modport source (output valid, is_release, event_code, event_tick, final_event,
                   input ready);
   modport sink   (input valid, is_release, event_code, event_tick, final_event,
                   output ready);
endinterface

interface kdmb_csr_if;
   import kdmb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ScansWidth-1:0] stable_scans;
   modport source (output valid, stable_scans, input ready);
   modport sink   (input valid, stable_scans, output ready);
endinterface
`default_nettype wire

### src/kdmb_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// One comparison lane: flags a key slot whose code is absent from the other set.
// Depends on kdmb_pkg.
module kdmb_lane (
   input  wire logic                           slot_used,
   input  wire logic [kdmb_pkg::CodeWidth-1:0] slot_code,
   input  wire logic [kdmb_pkg::CountWidth-1:0] other_count,
   input  wire logic [kdmb_pkg::SlotCount-1:0][kdmb_pkg::CodeWidth-1:0] other_codes,
   output logic                                hit
);
   import kdmb_pkg::*;

   logic [SlotCount-1:0] match;

   always_comb begin
      for (int i = 0; i < SlotCount; i++) begin
         match[i] = (other_count > CountWidth'(i)) && (other_codes[i] == slot_code);
      end
      hit = slot_used && (match == '0);
   end

endmodule
`default_nettype wire

### src/kdmb_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// Merge stage: holds the lane hits of one accepted set and serialises them as events.
// Depends on kdmb_pkg and kdmb_if.
module kdmb_merge (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire kdmb_pkg::event_batch_type  batch,
   output kdmb_pkg::drain_status_type      status,
   kdmb_rsp_if.source                      rsp
);
   import kdmb_pkg::*;

   logic [LaneCount-1:0]                pend_ff, pend_in;
   logic [LaneCount-1:0][CodeWidth-1:0] code_ff;
   logic [TickWidth-1:0]                tick_ff;
   logic [LaneIdxWidth-1:0]             sel;
   logic                                xfer;

   always_comb begin
      sel = '0;
      for (int i = LaneCount - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel = LaneIdxWidth'(i);
         end
      end
   end

   assign rsp.valid       = |pend_ff;
   assign rsp.is_release  = sel < FirstMakeLane;
   assign rsp.event_code  = code_ff[sel];
   assign rsp.event_tick  = tick_ff;
   assign rsp.final_event = (pend_ff & (pend_ff - LaneCount'(1))) == '0;
   assign xfer            = rsp.valid && rsp.ready;

   assign status.busy = rsp.valid;
   assign status.last = rsp.final_event;

   always_comb begin
      pend_in = pend_ff;
      if (xfer) begin
         pend_in[sel] = 1'b0;
      end
      if (load) begin
         pend_in = batch.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= batch.code;
         tick_ff <= batch.tick;
      end
   end

endmodule
`default_nettype wire

### src/key_debounce_make_break_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Key debounce with make/break events. Once a scan is taken, its events
// (up to four) appear from the next cycle, one per cycle while rsp is ready.
// A scan that yields events occupies the block until they have transferred; the
// next scan is taken in the cycle the last event transfers. Synchronous reset
// sets the hold count to 5 and clears the candidate, reported set and pending
// events; stable_scans returns to 7.
module key_debounce_make_break_core (
   input  wire logic  clock,
   input  wire logic  reset,
   kdmb_req_if.sink   req,
   kdmb_rsp_if.source rsp,
   kdmb_csr_if.sink   csr
);
   import kdmb_pkg::*;

   logic [ScansWidth-1:0]                stable_ff;
   logic [HoldWidth-1:0]                 hold_ff, hold_in;
   logic [CountWidth-1:0]                cand_n_ff, rep_n_ff, scan_n;
   logic [SlotCount-1:0][CodeWidth-1:0]  cand_ff, rep_ff, scan_codes;
   logic [HoldWidth:0]                   hold_inc;
   logic [ScansWidth-1:0]                thr;
   logic                                 xfer, differ, take_set;
   logic [LaneCount-1:0]                 hits;
   event_batch_type                      batch;
   drain_status_type                     status;

   assign csr.ready = 1'b1;
   assign req.ready = !status.busy || (status.last && rsp.ready);
   assign xfer      = req.valid && req.ready;

   always_comb begin
      scan_n        = (req.key_count > CountMax) ? CountMax : req.key_count;
      scan_codes[0] = (scan_n >= CountWidth'(1)) ? req.first_code  : '0;
      scan_codes[1] = (scan_n >= CountWidth'(2)) ? req.second_code : '0;
      differ        = (scan_codes != cand_ff) || (scan_n != cand_n_ff);
      hold_inc      = {1'b0, (differ ? HoldWidth'(0) : hold_ff)} + (HoldWidth + 1)'(1);
      thr           = (stable_ff == '0) ? ScansWidth'(1) : stable_ff;
      take_set      = hold_inc == {1'b0, thr};
      hold_in       = (hold_inc > {1'b0, thr}) ? thr : hold_inc[HoldWidth-1:0];
   end

   for (genvar g = 0; g < SlotCount; g++) begin : g_slot
      kdmb_lane u_break (
         .slot_used   (rep_n_ff > CountWidth'(g)),
         .slot_code   (rep_ff[g]),
         .other_count (scan_n),
         .other_codes (scan_codes),
         .hit         (hits[g])
      );
      kdmb_lane u_make (
         .slot_used   (scan_n > CountWidth'(g)),
         .slot_code   (scan_codes[g]),
         .other_count (rep_n_ff),
         .other_codes (rep_ff),
         .hit         (hits[SlotCount + g])
      );
   end

   always_comb begin
      batch.hit  = hits;
      batch.tick = req.tick_stamp;
      for (int i = 0; i < SlotCount; i++) begin
         batch.code[i]             = rep_ff[i];
         batch.code[SlotCount + i] = scan_codes[i];
      end
   end

   kdmb_merge u_merge (
      .clock  (clock),
      .reset  (reset),
      .load   (xfer && take_set),
      .batch  (batch),
      .status (status),
      .rsp    (rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= StableReset;
         hold_ff   <= HoldReset;
         cand_n_ff <= '0;
         cand_ff   <= '0;
         rep_n_ff  <= '0;
         rep_ff    <= '0;
      end else begin
         if (csr.valid) begin
            stable_ff <= csr.stable_scans;
         end
         if (xfer) begin
            hold_ff   <= hold_in;
            cand_n_ff <= scan_n;
            cand_ff   <= scan_codes;
            if (take_set) begin
               rep_n_ff <= scan_n;
               rep_ff   <= scan_codes;
            end
         end
      end
   end

endmodule
`default_nettype wire

### src/kdmb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for key_debounce_make_break_core, attached by bind.
// Depends on kdmb_pkg and the top level.
module kdmb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic                           rsp_is_release,
   input wire logic [kdmb_pkg::CodeWidth-1:0] rsp_event_code,
   input wire logic [kdmb_pkg::TickWidth-1:0] rsp_event_tick,
   input wire logic                           rsp_final_event
);
   import kdmb_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("events pending after reset");

   a_batch_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_event |=> rsp_valid)
      else $error("event batch broken before final transfer");

   a_no_take_mid_batch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_event |-> !req_ready)
      else $error("scan taken while events still pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_release) &&
      $stable(rsp_event_code) && $stable(rsp_event_tick) && $stable(rsp_final_event))
      else $error("stalled event changed");

endmodule

bind key_debounce_make_break_core kdmb_checker u_kdmb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_is_release  (rsp.is_release),
   .rsp_event_code  (rsp.event_code),
   .rsp_event_tick  (rsp.event_tick),
   .rsp_final_event (rsp.final_event)
);
`default_nettype wire
